// ===== rtl/core/ordered_multiset_rank_engine_defines.svh =====
// Assertion macros used by the core RTL.
`ifndef ORDERED_MULTISET_RANK_ENGINE_DEFINES_SVH
`define ORDERED_MULTISET_RANK_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define OMRE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define OMRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OMRE_ASSERT_NOW(label, ante, cons)
`define OMRE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/omre_pkg.sv =====
package omre_pkg;

    localparam int OMRE_CAPACITY = 256;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_DELETE = 3'd1;
    localparam logic [2:0] CMD_RANK   = 3'd2;
    localparam logic [2:0] CMD_SELECT = 3'd3;
    localparam logic [2:0] CMD_PRED   = 3'd4;
    localparam logic [2:0] CMD_SUCC   = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] operand;
    } t_ctl;

    typedef struct packed {
        logic ins;
        logic del;
    } t_wr;

endpackage

// ===== rtl/core/omre_cell.sv =====
module omre_cell #(
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  omre_pkg::t_ctl       i_ctl,
    input  omre_pkg::t_wr        i_wr,
    input  logic                 i_occ,
    input  logic signed [31:0]   i_left_key,
    input  logic signed [31:0]   i_right_key,
    input  logic                 i_left_lt,
    input  logic                 i_left_le,
    input  logic                 i_right_lt,
    output logic signed [31:0]   o_key,
    output logic                 o_lt,
    output logic                 o_le,
    output logic                 o_bound,
    output logic                 o_pick,
    output logic signed [31:0]   o_pick_key
);
    import omre_pkg::*;

    logic signed [31:0] r_key;
    logic signed [31:0] n_key;
    logic signed [31:0] b;
    logic               first_ge;
    logic               first_gt;

    assign b        = i_ctl.operand;
    assign o_lt     = i_occ && (r_key < b);
    assign o_le     = i_occ && (r_key <= b);
    assign o_bound  = o_lt && !i_right_lt;
    assign first_ge = !o_lt && i_left_lt;
    assign first_gt = !o_le && i_left_le;
    assign o_key    = r_key;

    always_comb begin
        case (i_ctl.cmd)
            CMD_DELETE: o_pick = i_occ && first_ge && (r_key == b);
            CMD_SELECT: o_pick = i_occ && ($unsigned(i_ctl.operand) == 32'(IDX + 1));
            CMD_PRED:   o_pick = o_bound;
            CMD_SUCC:   o_pick = i_occ && first_gt;
            default:    o_pick = 1'b0;
        endcase
    end

    assign o_pick_key = o_pick ? r_key : 32'sd0;

    // insert opens a slot at the first key above b; delete closes the gap
    always_comb begin
        n_key = r_key;
        if (i_wr.ins && !o_le) begin
            n_key = first_gt ? b : i_left_key;
        end else if (i_wr.del && !o_lt) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

// ===== rtl/core/ordered_multiset_rank_engine.sv =====
// channel  valid         stall         payload
// request  i_in_valid    o_in_stall    i_command, i_operand
// result   o_out_valid   i_out_stall   o_answer, o_status
//
// Each request is captured first, then handled in a compare step in which every cell
// compares against the operand, the chain shifts and the result register loads.
// The compare step waits while a previous result is held by i_out_stall.
// Reset (synchronous, i_rst_n low) empties the store and both handshakes.
// o_in_stall stays high from accept until the compare step fires.
`include "ordered_multiset_rank_engine_defines.svh"

module ordered_multiset_rank_engine #(
    parameter int CAPACITY = omre_pkg::OMRE_CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [2:0]          i_command,
    input  logic signed [31:0]  i_operand,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [31:0]  o_answer,
    output logic [1:0]          o_status
);
    import omre_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = $clog2(CAPACITY + 2);

    logic               r_busy;
    logic               n_busy;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [2:0]         r_cmd;
    logic signed [31:0] r_operand;
    logic signed [31:0] r_answer;
    logic signed [31:0] n_answer;
    logic [1:0]         r_status;
    logic [1:0]         n_status;

    logic               accept;
    logic               fire;
    logic               full;
    t_ctl               ctl;
    t_wr                wr;

    logic               occ      [CAPACITY];
    logic signed [31:0] key      [CAPACITY];
    logic               lt       [CAPACITY];
    logic               le       [CAPACITY];
    logic               bound    [CAPACITY];
    logic               pick     [CAPACITY];
    logic [CAPACITY-1:0] pick_vec;
    logic signed [31:0] pick_key [CAPACITY];

    logic               any_pick;
    logic signed [31:0] hit_key;
    logic [RW-1:0]      rank_or;

    assign accept      = i_in_valid && !r_busy;
    assign o_in_stall  = r_busy;
    assign fire        = r_busy && (!r_out_valid || !i_out_stall);
    assign full        = (r_count == CW'(CAPACITY));
    assign o_out_valid = r_out_valid;
    assign o_answer    = r_answer;
    assign o_status    = r_status;

    assign ctl.cmd     = r_cmd;
    assign ctl.operand = r_operand;
    assign wr.ins      = fire && (r_cmd == CMD_INSERT) && !full;
    assign wr.del      = fire && (r_cmd == CMD_DELETE) && any_pick;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            occ[i] = (CW'(i) < r_count);
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [31:0] left_key;
        logic signed [31:0] right_key;
        logic               left_lt;
        logic               left_le;
        logic               right_lt;

        if (g == 0) begin : g_first
            assign left_key = r_operand;
            assign left_lt  = 1'b1;
            assign left_le  = 1'b1;
        end else begin : g_mid_l
            assign left_key = key[g-1];
            assign left_lt  = lt[g-1];
            assign left_le  = le[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_key = key[g];
            assign right_lt  = 1'b0;
        end else begin : g_mid_r
            assign right_key = key[g+1];
            assign right_lt  = lt[g+1];
        end

        omre_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_wr        (wr),
            .i_occ       (occ[g]),
            .i_left_key  (left_key),
            .i_right_key (right_key),
            .i_left_lt   (left_lt),
            .i_left_le   (left_le),
            .i_right_lt  (right_lt),
            .o_key       (key[g]),
            .o_lt        (lt[g]),
            .o_le        (le[g]),
            .o_bound     (bound[g]),
            .o_pick      (pick[g]),
            .o_pick_key  (pick_key[g])
        );

        assign pick_vec[g] = pick[g];
    end

    always_comb begin
        any_pick = 1'b0;
        hit_key  = 32'sd0;
        rank_or  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            any_pick = any_pick | pick[i];
            hit_key  = hit_key | pick_key[i];
            if (bound[i]) begin
                rank_or = rank_or | RW'(i + 2);
            end
        end
    end

    always_comb begin
        n_answer = 32'sd0;
        n_status = ST_OK;
        n_count  = r_count;
        case (r_cmd)
            CMD_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            CMD_DELETE: begin
                if (any_pick) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_status = ST_ABSENT;
                end
            end
            CMD_RANK: begin
                n_answer = (rank_or == '0) ? 32'sd1 : signed'(32'(rank_or));
            end
            CMD_SELECT: begin
                n_answer = hit_key;
                n_status = any_pick ? ST_OK : ST_ABSENT;
            end
            CMD_PRED: begin
                n_answer = any_pick ? hit_key : KEY_MIN;
                n_status = any_pick ? ST_OK : ST_ABSENT;
            end
            CMD_SUCC: begin
                n_answer = any_pick ? hit_key : KEY_MAX;
                n_status = any_pick ? ST_OK : ST_ABSENT;
            end
            default: begin
                n_status = ST_ABSENT;
            end
        endcase
    end

    assign n_busy      = accept ? 1'b1 : (fire ? 1'b0 : r_busy);
    assign n_out_valid = fire ? 1'b1 : (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            if (fire) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= i_command;
            r_operand <= i_operand;
        end
        if (fire) begin
            r_answer <= n_answer;
            r_status <= n_status;
        end
    end

    `OMRE_ASSERT_NOW(a_count_range, 1'b1, r_count <= CW'(CAPACITY))
    `OMRE_ASSERT_NOW(a_single_pick, r_busy, $onehot0(pick_vec))
    `OMRE_ASSERT_NEXT(a_insert_grows, wr.ins, r_count == $past(r_count) + CW'(1))
    `OMRE_ASSERT_NEXT(a_fire_result, fire, r_out_valid && !r_busy)

endmodule

// ===== sim/omre_rank_checker.sv =====
`timescale 1ns / 100ps

module omre_rank_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_operand,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_answer,
    input  logic [1:0]         i_status,
    output int                 o_fail_count,
    output int                 o_pending
);
    import omre_pkg::*;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] answer;
        logic [1:0]         status;
    } t_rank_result;

    // ascending copy of the multiset
    logic signed [31:0] stored_keys[$];
    t_rank_result       awaited_q[$];
    t_rank_result       head;
    int                 mismatches;

    function automatic int count_below(input logic signed [31:0] x);
        int n;
        n = 0;
        foreach (stored_keys[i]) begin
            if (stored_keys[i] < x) n++;
        end
        return n;
    endfunction

    function automatic int count_at_most(input logic signed [31:0] x);
        int n;
        n = 0;
        foreach (stored_keys[i]) begin
            if (stored_keys[i] <= x) n++;
        end
        return n;
    endfunction

    // Updates the multiset and returns the result the request should produce.
    function automatic t_rank_result apply_request(input logic [2:0] cmd,
                                                   input logic signed [31:0] x);
        t_rank_result r;
        int           pos;
        r.cmd    = cmd;
        r.answer = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_INSERT: begin
                if (stored_keys.size() >= OMRE_CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    pos = count_at_most(x);
                    stored_keys.insert(pos, x);
                end
            end
            CMD_DELETE: begin
                pos = count_below(x);
                if (pos < stored_keys.size() && stored_keys[pos] == x) begin
                    stored_keys.delete(pos);
                end else begin
                    r.status = ST_ABSENT;
                end
            end
            CMD_RANK: begin
                r.answer = count_below(x) + 1;
            end
            CMD_SELECT: begin
                if (x < 1 || x > stored_keys.size()) begin
                    r.status = ST_ABSENT;
                end else begin
                    r.answer = stored_keys[x - 1];
                end
            end
            CMD_PRED: begin
                pos = count_below(x);
                if (pos == 0) begin
                    r.answer = KEY_MIN;
                    r.status = ST_ABSENT;
                end else begin
                    r.answer = stored_keys[pos - 1];
                end
            end
            CMD_SUCC: begin
                pos = count_at_most(x);
                if (pos >= stored_keys.size()) begin
                    r.answer = KEY_MAX;
                    r.status = ST_ABSENT;
                end else begin
                    r.answer = stored_keys[pos];
                end
            end
            default: begin
                r.status = ST_ABSENT;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored_keys.delete();
            awaited_q.delete();
        end else begin
            // a result never leaves in the cycle its request is accepted, so check first
            if (i_out_valid && !i_out_stall) begin
                if (awaited_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result answer=%0d status=%0d",
                                 $realtime, i_answer, i_status);
                    end
                end else begin
                    head = awaited_q.pop_front();
                    if (i_answer !== head.answer || i_status !== head.status) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: cmd %0d answer exp %0d got %0d, status exp %0d got %0d",
                                     $realtime, head.cmd, head.answer, i_answer,
                                     head.status, i_status);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_q.push_back(apply_request(i_command, i_operand));
            end
        end
        o_pending    <= awaited_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== sim/tb_ordered_multiset_rank_engine.sv =====
`timescale 1ns / 100ps

module tb_ordered_multiset_rank_engine;
    import omre_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TIMEOUT_NS    = 2_000_000;

    localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [2:0]         i_command;
    logic signed [31:0] i_operand;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_answer;
    logic [1:0]         o_status;

    int fail_count;
    int pending;
    int idle_pct;
    int stall_pct;

    // unordered copy of what the store holds, for picking operands
    logic signed [31:0] live_keys[$];

    ordered_multiset_rank_engine i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_operand   (i_operand),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_answer    (o_answer),
        .o_status    (o_status)
    );

    omre_rank_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_operand    (i_operand),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_answer     (o_answer),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic signed [31:0] extreme_key();
        case ($urandom_range(0, 6))
            0: return KEY_MIN;
            1: return KEY_MIN + 1;
            2: return -1;
            3: return 0;
            4: return 1;
            5: return KEY_MAX - 1;
            default: return KEY_MAX;
        endcase
    endfunction

    function automatic logic signed [31:0] some_key();
        int r;
        r = $urandom_range(0, 99);
        if (live_keys.size() > 0 && r < 40) begin
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        end
        if (live_keys.size() > 0 && r < 55) begin
            return live_keys[$urandom_range(0, live_keys.size() - 1)]
                   + ($urandom_range(0, 1) ? 1 : -1);
        end
        if (r < 72) return $urandom_range(0, 15) - 8;
        if (r < 80) return extreme_key();
        return $urandom;
    endfunction

    function automatic logic signed [31:0] select_rank();
        int n;
        n = live_keys.size();
        if (n > 0 && $urandom_range(0, 99) < 80) return $urandom_range(1, n);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return n + 1;
            2: return -1;
            3: return KEY_MIN;
            4: return KEY_MAX;
            default: return $urandom;
        endcase
    endfunction

    task automatic issue_request(input logic [2:0] cmd, input logic signed [31:0] key);
        if ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_operand  <= key;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        if (cmd == CMD_INSERT && live_keys.size() < OMRE_CAPACITY) begin
            live_keys.push_back(key);
        end
        if (cmd == CMD_DELETE) begin
            for (int i = 0; i < live_keys.size(); i++) begin
                if (live_keys[i] == key) begin
                    live_keys.delete(i);
                    break;
                end
            end
        end
    endtask

    task automatic random_request(input int ins_pct, input int del_pct);
        int                 r;
        logic [2:0]         cmd;
        logic signed [31:0] key;
        r = $urandom_range(0, 99);
        if (r < ins_pct) begin
            cmd = CMD_INSERT;
            key = some_key();
        end else if (r < ins_pct + del_pct) begin
            cmd = CMD_DELETE;
            if (live_keys.size() > 0 && $urandom_range(0, 99) < 85) begin
                key = live_keys[$urandom_range(0, live_keys.size() - 1)];
            end else begin
                key = some_key();
            end
        end else if (r >= 97) begin
            cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
            key = $urandom;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    cmd = CMD_RANK;
                    key = some_key();
                end
                1: begin
                    cmd = CMD_SELECT;
                    key = select_rank();
                end
                2: begin
                    cmd = CMD_PRED;
                    key = some_key();
                end
                default: begin
                    cmd = CMD_SUCC;
                    key = some_key();
                end
            endcase
        end
        issue_request(cmd, key);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_command   = CMD_INSERT;
        i_operand   = '0;
        i_out_stall = 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty store
        issue_request(CMD_PRED, 0);
        issue_request(CMD_SUCC, 0);
        issue_request(CMD_SELECT, 1);
        issue_request(CMD_RANK, KEY_MIN);
        issue_request(CMD_DELETE, 5);
        issue_request(CMD_UNUSED_LO, KEY_MAX);
        issue_request(CMD_UNUSED_HI, KEY_MIN);
        // extremes and duplicates
        issue_request(CMD_INSERT, KEY_MIN);
        issue_request(CMD_INSERT, KEY_MAX);
        issue_request(CMD_INSERT, 0);
        issue_request(CMD_INSERT, 0);
        issue_request(CMD_INSERT, -1);
        issue_request(CMD_RANK, 0);
        issue_request(CMD_RANK, KEY_MAX);
        issue_request(CMD_SELECT, 5);
        issue_request(CMD_SELECT, 6);
        issue_request(CMD_SELECT, 0);
        issue_request(CMD_SELECT, -1);
        issue_request(CMD_PRED, KEY_MIN);
        issue_request(CMD_PRED, 0);
        issue_request(CMD_SUCC, KEY_MAX);
        issue_request(CMD_SUCC, 0);
        issue_request(CMD_DELETE, 0);
        issue_request(CMD_DELETE, 0);
        issue_request(CMD_DELETE, 0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 500 == 0) begin
                if (i > 0) drain_results();
                case (i / 500)
                    0: begin
                        idle_pct  = 0;
                        stall_pct = 0;
                    end
                    1: begin
                        idle_pct  = 55;
                        stall_pct = 0;
                    end
                    2: begin
                        idle_pct  = 0;
                        stall_pct = 55;
                    end
                    default: begin
                        idle_pct  = 12;
                        stall_pct = 12;
                    end
                endcase
            end
            // fill to capacity, churn, empty out, then fill and empty once more
            case (i / 400)
                0, 3: random_request(80, 4);
                1: random_request(30, 25);
                default: random_request(5, 78);
            endcase
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
